// ----- rtl/mfd_pkg.sv -----
// Shared constants and types for the meter frame decoder.
package mfd_pkg;

  localparam int FRAME_BYTES = 11;
  localparam int NUM_DIGITS  = 5;
  localparam int CNT_W       = 4;

  // The count parks here when bytes keep arriving after the frame is full.
  localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(FRAME_BYTES + 1);

  localparam logic [7:0] TERM_RESET = 8'h0A;

  // Byte positions inside the frame.
  localparam int IDX_FN    = 1;
  localparam int IDX_RANGE = 2;
  localparam int IDX_FLAGS = 4;
  localparam int IDX_DIG0  = 5;

  localparam logic [16:0] MAG_MAX    = 17'd99999;
  localparam logic [2:0]  PLACES_MAX = 3'd5;
  localparam logic [2:0]  MODE_DUTY  = 3'd5;
  localparam logic [7:0]  ASCII_ZERO = 8'h30;
  localparam logic [7:0]  ASCII_NINE = 8'h39;

  // Function codes.
  localparam logic [7:0] FN_VOLT     = 8'd248;
  localparam logic [7:0] FN_VOLT_AC  = 8'd240;
  localparam logic [7:0] FN_MVOLT    = 8'd232;
  localparam logic [7:0] FN_AMP      = 8'd168;
  localparam logic [7:0] FN_AMP_ALT  = 8'd169;
  localparam logic [7:0] FN_MAMP     = 8'd176;
  localparam logic [7:0] FN_MAMP_ALT = 8'd177;
  localparam logic [7:0] FN_OHM      = 8'd224;
  localparam logic [7:0] FN_CAP      = 8'd225;

  // Unit codes.
  localparam logic [3:0] UNIT_NONE = 4'd0;
  localparam logic [3:0] UNIT_MV   = 4'd1;
  localparam logic [3:0] UNIT_V    = 4'd2;
  localparam logic [3:0] UNIT_MA   = 4'd3;
  localparam logic [3:0] UNIT_A    = 4'd4;
  localparam logic [3:0] UNIT_OHM  = 4'd5;
  localparam logic [3:0] UNIT_KOHM = 4'd6;
  localparam logic [3:0] UNIT_MOHM = 4'd7;
  localparam logic [3:0] UNIT_NS   = 4'd8;
  localparam logic [3:0] UNIT_NF   = 4'd9;
  localparam logic [3:0] UNIT_UF   = 4'd10;
  localparam logic [3:0] UNIT_HZ   = 4'd11;
  localparam logic [3:0] UNIT_KHZ  = 4'd12;
  localparam logic [3:0] UNIT_PCT  = 4'd13;

  // Frame bytes that the decode actually looks at; digits[0] is the leading digit.
  typedef struct packed {
    logic [7:0]                 fn;
    logic [7:0]                 rng_byte;
    logic [7:0]                 flags;
    logic [NUM_DIGITS-1:0][7:0] digits;
  } frame_t;

  typedef struct packed {
    logic [16:0] magnitude;
    logic [2:0]  decimal_places;
    logic [3:0]  unit;
    logic        negative;
    logic        overload;
    logic        auto_range;
    logic        hold;
    logic        five_digit;
    logic        digit_error;
  } result_t;

endpackage

// ----- rtl/multimeter_frame_decoder.sv -----
// Top level of the meter frame decoder: configuration, output register and wiring.
//
// The block takes one received meter byte per clock cycle and gathers the bytes of an
// eleven-byte frame. When the terminator byte arrives right after exactly eleven data
// bytes, the frame is decoded into one reading: digit magnitude, sign, decimal places,
// unit code and the overload, auto-range and hold flags. Every terminator restarts the
// count, so short or overlong frames give no reading. A byte is held in the input
// register; once the terminator sits there and the output register is free, the
// reading is loaded into the output register and out_valid is set. The whole decode
// is a short combinational path from the frame store to the output register. Throughput
// is one byte per cycle for as long as the output side takes its transfers; a reading
// that waits on out_stall holds the input only when the next terminator needs the
// output register. The terminator value is written through the cfg port (resets to
// line feed) and must only change while no byte is in flight.
module multimeter_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_magnitude,
  output logic [2:0]  out_decimal_places,
  output logic [3:0]  out_unit,
  output logic        out_negative,
  output logic        out_overload,
  output logic        out_auto_range,
  output logic        out_hold,
  output logic        out_five_digit,
  output logic        out_digit_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_terminator_byte
);

  logic [7:0]       term_r;
  logic             out_vld_r;
  logic             out_vld_nxt;
  mfd_pkg::result_t res_r;
  mfd_pkg::result_t res;
  mfd_pkg::frame_t  frame;
  logic             slot_free;
  logic             fire;

  // The configuration register is always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r <= mfd_pkg::TERM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      term_r <= cfg_terminator_byte;
    end
  end

  // The output register can take a new reading when it is empty or is
  // completing its transfer in this cycle.
  assign slot_free = !out_vld_r || !out_stall;

  mfd_collect u_collect (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .terminator_byte (term_r),
    .slot_free       (slot_free),
    .frame           (frame),
    .fire            (fire)
  );

  mfd_decode u_decode (
    .frame (frame),
    .res   (res)
  );

  always_comb begin
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_magnitude      = res_r.magnitude;
  assign out_decimal_places = res_r.decimal_places;
  assign out_unit           = res_r.unit;
  assign out_negative       = res_r.negative;
  assign out_overload       = res_r.overload;
  assign out_auto_range     = res_r.auto_range;
  assign out_hold           = res_r.hold;
  assign out_five_digit     = res_r.five_digit;
  assign out_digit_error    = res_r.digit_error;

  // A decoded frame must land in the output register.
  a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("decoded frame did not reach the output");

  // A waiting reading must never be overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |-> !fire)
    else $error("reading overwritten while stalled");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ((res_r.magnitude <= mfd_pkg::MAG_MAX) &&
                   (res_r.decimal_places <= mfd_pkg::PLACES_MAX) &&
                   (res_r.unit <= mfd_pkg::UNIT_PCT)))
    else $error("reading field out of range");

endmodule

// ----- rtl/mfd_collect.sv -----
// Input register, byte count and frame store of the meter frame decoder.
module mfd_collect (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_rx_byte,
  input  logic [7:0]          terminator_byte,
  input  logic                slot_free,
  output mfd_pkg::frame_t     frame,
  output logic                fire
);

  logic [7:0]                  byte_r;
  logic                        vld_r;
  logic [mfd_pkg::CNT_W-1:0]   cnt_r;
  logic [mfd_pkg::CNT_W-1:0]   cnt_nxt;
  mfd_pkg::frame_t             frame_r;
  logic                        is_term;
  logic                        want;
  logic                        go;
  logic [2:0]                  dig_idx;
  logic                        dig_hit;

  assign is_term = (byte_r == terminator_byte);
  assign want    = vld_r && is_term && (cnt_r == mfd_pkg::CNT_W'(mfd_pkg::FRAME_BYTES));
  // A held byte moves on unless it must load a result and the output is occupied.
  assign go       = vld_r && (!want || slot_free);
  assign fire     = want && slot_free;
  assign in_stall = vld_r && !go;
  assign frame    = frame_r;

  assign dig_idx = 3'(cnt_r - mfd_pkg::CNT_W'(mfd_pkg::IDX_DIG0));
  assign dig_hit = (cnt_r >= mfd_pkg::CNT_W'(mfd_pkg::IDX_DIG0)) &&
                   (cnt_r < mfd_pkg::CNT_W'(mfd_pkg::IDX_DIG0 + mfd_pkg::NUM_DIGITS));

  always_comb begin
    if (is_term) begin
      cnt_nxt = '0;
    end else if (cnt_r < mfd_pkg::CNT_W'(mfd_pkg::FRAME_BYTES)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      cnt_nxt = mfd_pkg::CNT_OVER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (!in_stall) begin
        vld_r <= in_valid;
      end
      if (go) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_rx_byte;
    end
    if (go && !is_term) begin
      if (cnt_r == mfd_pkg::CNT_W'(mfd_pkg::IDX_FN)) begin
        frame_r.fn <= byte_r;
      end
      if (cnt_r == mfd_pkg::CNT_W'(mfd_pkg::IDX_RANGE)) begin
        frame_r.rng_byte <= byte_r;
      end
      if (cnt_r == mfd_pkg::CNT_W'(mfd_pkg::IDX_FLAGS)) begin
        frame_r.flags <= byte_r;
      end
      if (dig_hit) begin
        frame_r.digits[dig_idx] <= byte_r;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mfd_pkg::CNT_OVER)
    else $error("byte count past overlong mark");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (go && is_term) |=> (cnt_r == '0))
    else $error("terminator did not clear the byte count");

endmodule

// ----- rtl/mfd_decode.sv -----
// Combinational decode of a complete frame into one reading.
module mfd_decode (
  input  mfd_pkg::frame_t  frame,
  output mfd_pkg::result_t res
);

  logic [2:0]        rng;
  logic              five;
  logic              duty;
  logic [3:0]        d [mfd_pkg::NUM_DIGITS];
  logic [17:0]       mag_sum;
  logic              derr;
  logic signed [4:0] places;
  logic signed [4:0] rng_s;
  logic [1:0]        rng_mod3;
  logic [3:0]        unit_sel;
  logic [2:0]        places_sat;

  assign rng   = frame.rng_byte[5:3];
  assign five  = frame.flags[2];
  assign duty  = (frame.rng_byte[2:0] == mfd_pkg::MODE_DUTY);
  assign rng_s = signed'({2'b00, rng});

  // Digit bytes add the low nibble, decimal or not (digit 0 only if five-digit).
  always_comb begin
    derr = 1'b0;
    for (int i = 0; i < mfd_pkg::NUM_DIGITS; i++) begin
      d[i] = frame.digits[i][3:0];
      if ((i != 0) || five) begin
        if ((frame.digits[i] < mfd_pkg::ASCII_ZERO) || (frame.digits[i] > mfd_pkg::ASCII_NINE)) begin
          derr = 1'b1;
        end
      end
    end
    if (!five) begin
      d[0] = 4'd0;
    end
  end

  assign mag_sum = 18'(d[0]) * 18'd10000 + 18'(d[1]) * 18'd1000 +
                   18'(d[2]) * 18'd100 + 18'(d[3]) * 18'd10 + 18'(d[4]);

  always_comb begin
    case (rng)
      3'd0, 3'd3, 3'd6: rng_mod3 = 2'd0;
      3'd1, 3'd4, 3'd7: rng_mod3 = 2'd1;
      default:          rng_mod3 = 2'd2;
    endcase
  end

  always_comb begin
    places   = 5'sd0;
    unit_sel = mfd_pkg::UNIT_NONE;
    if (five) begin
      if (rng <= 3'd1) begin
        places   = 5'sd1 + rng_s;
        unit_sel = mfd_pkg::UNIT_HZ;
      end else begin
        places   = 5'sd6 - rng_s;
        unit_sel = mfd_pkg::UNIT_KHZ;
      end
    end else if (duty) begin
      places   = 5'sd2;
      unit_sel = mfd_pkg::UNIT_PCT;
    end else begin
      case (frame.fn)
        mfd_pkg::FN_VOLT: begin
          if (rng == 3'd0) begin
            places   = 5'sd1;
            unit_sel = mfd_pkg::UNIT_MV;
          end else begin
            places   = 5'sd4 - rng_s;
            unit_sel = mfd_pkg::UNIT_V;
          end
        end
        mfd_pkg::FN_VOLT_AC: begin
          places   = 5'sd3 - rng_s;
          unit_sel = mfd_pkg::UNIT_V;
        end
        mfd_pkg::FN_MVOLT: begin
          places   = 5'sd2 - rng_s;
          unit_sel = mfd_pkg::UNIT_MV;
        end
        mfd_pkg::FN_AMP, mfd_pkg::FN_AMP_ALT: begin
          places   = 5'sd3 - rng_s;
          unit_sel = mfd_pkg::UNIT_A;
        end
        mfd_pkg::FN_MAMP, mfd_pkg::FN_MAMP_ALT: begin
          places   = 5'sd2 - rng_s;
          unit_sel = mfd_pkg::UNIT_MA;
        end
        mfd_pkg::FN_OHM: begin
          if (rng == 3'd0) begin
            places   = 5'sd3;
            unit_sel = mfd_pkg::UNIT_OHM;
          end else if (rng <= 3'd3) begin
            places   = 5'sd4 - rng_s;
            unit_sel = mfd_pkg::UNIT_KOHM;
          end else if (rng <= 3'd5) begin
            places   = 5'sd7 - rng_s;
            unit_sel = mfd_pkg::UNIT_MOHM;
          end else begin
            places   = 5'sd2;
            unit_sel = (rng == 3'd6) ? mfd_pkg::UNIT_NS : mfd_pkg::UNIT_NONE;
          end
        end
        mfd_pkg::FN_CAP: begin
          places   = 5'sd3 - signed'({3'b000, rng_mod3});
          unit_sel = (rng <= 3'd2) ? mfd_pkg::UNIT_NF : mfd_pkg::UNIT_UF;
        end
        default: begin
          places   = 5'sd0;
          unit_sel = mfd_pkg::UNIT_NONE;
        end
      endcase
    end
  end

  always_comb begin
    if (places < 5'sd0) begin
      places_sat = 3'd0;
    end else if (places > signed'({2'b00, mfd_pkg::PLACES_MAX})) begin
      places_sat = mfd_pkg::PLACES_MAX;
    end else begin
      places_sat = places[2:0];
    end
  end

  assign res.magnitude      = (mag_sum > 18'(mfd_pkg::MAG_MAX)) ? mfd_pkg::MAG_MAX : mag_sum[16:0];
  assign res.decimal_places = places_sat;
  assign res.unit           = unit_sel;
  assign res.negative       = frame.flags[4];
  assign res.overload       = frame.flags[3];
  assign res.auto_range     = !frame.rng_byte[6];
  assign res.hold           = frame.flags[0];
  assign res.five_digit     = five;
  assign res.digit_error    = derr;

endmodule

// ----- dv/multimeter_frame_decoder_tb.sv -----
// Self-checking testbench for the meter frame decoder: directed frames, then random traffic.
module multimeter_frame_decoder_tb;

  // How the expected reading of a stimulus row is obtained. Most rows are checked against
  // the predictor below; a few carry the reading typed in, and some must give no reading.
  typedef enum logic [1:0] {
    EXP_PREDICTED,
    EXP_LISTED,
    EXP_NONE
  } exp_kind_t;

  typedef struct packed {
    logic [7:0]       fn;
    logic [7:0]       rng_byte;
    logic [7:0]       flags;
    logic [39:0]      digits;   // frame bytes 5..9, byte 5 in the top eight bits
    logic [3:0]       length;   // data bytes sent before the terminator
    exp_kind_t        kind;
    mfd_pkg::result_t reading;
  } frame_row_t;

  localparam mfd_pkg::result_t NO_READING = '0;

  // Directed frames, sent with the reset terminator (line feed). The first three rows are
  // the extremes: an all-zero reading, a full-scale five-digit reading with the sign,
  // overload and hold flags set, and a five-digit frame of non-digit bytes whose sum
  // saturates and whose frequency range would need a negative exponent.
  localparam int NUM_ROWS = 24;
  localparam frame_row_t PLAN [NUM_ROWS] = '{
    '{8'd248, 8'h00, 8'h00, "00000", 4'd11, EXP_LISTED,
      '{17'd0, 3'd1, mfd_pkg::UNIT_MV, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'h00, 8'h40, 8'h1D, "99999", 4'd11, EXP_LISTED,
      '{mfd_pkg::MAG_MAX, 3'd1, mfd_pkg::UNIT_HZ, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{8'hFF, 8'h38, 8'h04, 40'hFF_FF_FF_FF_FF, 4'd11, EXP_LISTED,
      '{mfd_pkg::MAG_MAX, 3'd0, mfd_pkg::UNIT_KHZ, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}},
    // A frame one byte short, one byte long, and a terminator right after a terminator.
    '{8'd248, 8'h00, 8'h00, "12345", 4'd10, EXP_NONE, NO_READING},
    '{8'd248, 8'h00, 8'h00, "12345", 4'd12, EXP_NONE, NO_READING},
    '{8'd248, 8'h00, 8'h00, "12345", 4'd0,  EXP_NONE, NO_READING},
    // Every function code, the resistance corner ranges, duty, frequency and unknown codes.
    '{mfd_pkg::FN_VOLT_AC,  8'h18, 8'h08, "01234", 4'd11, EXP_PREDICTED, NO_READING},
    '{mfd_pkg::FN_MVOLT,    8'h08, 8'h01, "55555", 4'd11, EXP_PREDICTED, NO_READING},
    '{mfd_pkg::FN_AMP,      8'h10, 8'h10, "98765", 4'd11, EXP_PREDICTED, NO_READING},
    '{mfd_pkg::FN_AMP_ALT,  8'h40, 8'h00, "00001", 4'd11, EXP_PREDICTED, NO_READING},
    '{mfd_pkg::FN_MAMP,     8'h20, 8'h00, "43210", 4'd11, EXP_PREDICTED, NO_READING},
    '{mfd_pkg::FN_MAMP_ALT, 8'h08, 8'h00, "11111", 4'd11, EXP_PREDICTED, NO_READING},
    '{mfd_pkg::FN_OHM,      8'h00, 8'h00, "02468", 4'd11, EXP_PREDICTED, NO_READING},
    '{mfd_pkg::FN_OHM,      8'h10, 8'h00, "13579", 4'd11, EXP_PREDICTED, NO_READING},
    '{mfd_pkg::FN_OHM,      8'h28, 8'h00, "24680", 4'd11, EXP_PREDICTED, NO_READING},
    '{mfd_pkg::FN_OHM,      8'h30, 8'h00, "00042", 4'd11, EXP_PREDICTED, NO_READING},
    '{mfd_pkg::FN_OHM,      8'h38, 8'h00, "00777", 4'd11, EXP_PREDICTED, NO_READING},
    '{mfd_pkg::FN_CAP,      8'h08, 8'h00, "31415", 4'd11, EXP_PREDICTED, NO_READING},
    '{mfd_pkg::FN_CAP,      8'h20, 8'h00, "27182", 4'd11, EXP_PREDICTED, NO_READING},
    '{mfd_pkg::FN_VOLT,     8'h05, 8'h00, "05000", 4'd11, EXP_PREDICTED, NO_READING},
    '{mfd_pkg::FN_VOLT,     8'h08, 8'h04, "12345", 4'd11, EXP_PREDICTED, NO_READING},
    '{8'd12,                8'h00, 8'h00, "9:A/Z", 4'd11, EXP_PREDICTED, NO_READING},
    '{mfd_pkg::FN_VOLT,     8'h18, 8'h00, "00010", 4'd11, EXP_PREDICTED, NO_READING},
    '{mfd_pkg::FN_VOLT,     8'h38, 8'h00, "99999", 4'd11, EXP_PREDICTED, NO_READING}
  };

  // Terminator settings for the random phases; one phase draws its value at random.
  localparam int NUM_PHASES = 7;
  localparam int RANDOM_PHASE = 3;
  localparam logic [7:0] TERM_PLAN [NUM_PHASES] =
    '{8'h00, 8'hFF, 8'h0D, 8'h00, 8'h30, 8'h7E, mfd_pkg::TERM_RESET};
  localparam int BYTES_PER_PHASE = 145;

  localparam logic [7:0] FN_LIST [9] = '{mfd_pkg::FN_VOLT, mfd_pkg::FN_VOLT_AC,
                                         mfd_pkg::FN_MVOLT, mfd_pkg::FN_AMP,
                                         mfd_pkg::FN_AMP_ALT, mfd_pkg::FN_MAMP,
                                         mfd_pkg::FN_MAMP_ALT, mfd_pkg::FN_OHM,
                                         mfd_pkg::FN_CAP};

  // A byte passes through the input register and the reading through the output register, so
  // nothing can be left in flight once the drain wait after the last reading is over.
  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_LIMIT = 1000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [16:0] out_magnitude;
  logic [2:0]  out_decimal_places;
  logic [3:0]  out_unit;
  logic        out_negative;
  logic        out_overload;
  logic        out_auto_range;
  logic        out_hold;
  logic        out_five_digit;
  logic        out_digit_error;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_terminator_byte;

  // Predictor state: the frame gathered so far, its byte count and the terminator in use.
  logic [7:0] frame_bytes [mfd_pkg::FRAME_BYTES];
  int         fill_count = 0;
  logic [7:0] terminator = mfd_pkg::TERM_RESET;

  mfd_pkg::result_t readings_due [$];
  logic [7:0]       frame_buf [mfd_pkg::FRAME_BYTES + 2];
  int               bytes_sent = 0;
  bit               calm = 1'b0;
  bit               failed = 1'b0;

  multimeter_frame_decoder dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_magnitude       (out_magnitude),
    .out_decimal_places  (out_decimal_places),
    .out_unit            (out_unit),
    .out_negative        (out_negative),
    .out_overload        (out_overload),
    .out_auto_range      (out_auto_range),
    .out_hold            (out_hold),
    .out_five_digit      (out_five_digit),
    .out_digit_error     (out_digit_error),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_terminator_byte (cfg_terminator_byte)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Decodes the gathered frame into the reading the block should give.
  function automatic mfd_pkg::result_t decode_reading();
    logic [7:0]       fn;
    logic [7:0]       rb;
    logic [7:0]       fb;
    logic [7:0]       c;
    logic             five;
    logic [31:0]      mag;
    int               rng;
    int               places;
    mfd_pkg::result_t r;
    fn = frame_bytes[mfd_pkg::IDX_FN];
    rb = frame_bytes[mfd_pkg::IDX_RANGE];
    fb = frame_bytes[mfd_pkg::IDX_FLAGS];
    rng = int'(rb[5:3]);
    five = fb[2];
    r = '0;
    mag = 0;
    // The leading digit only counts in five-digit mode.
    for (int i = five ? mfd_pkg::IDX_DIG0 : mfd_pkg::IDX_DIG0 + 1;
         i < mfd_pkg::IDX_DIG0 + mfd_pkg::NUM_DIGITS; i++) begin
      c = frame_bytes[i];
      if (c >= mfd_pkg::ASCII_ZERO && c <= mfd_pkg::ASCII_NINE) begin
        mag = mag * 10 + 32'(c - mfd_pkg::ASCII_ZERO);
      end else begin
        mag = mag * 10 + 32'(c[3:0]);
        r.digit_error = 1'b1;
      end
    end
    r.magnitude = (mag > 32'(mfd_pkg::MAG_MAX)) ? mfd_pkg::MAG_MAX : mag[16:0];
    // Five-digit mode always reads as frequency, so the extra digit never shifts the
    // decimal point of the other functions.
    places = 0;
    r.unit = mfd_pkg::UNIT_NONE;
    if (five) begin
      if (rng <= 1) begin
        places = 1 + rng;
        r.unit = mfd_pkg::UNIT_HZ;
      end else begin
        places = 6 - rng;
        r.unit = mfd_pkg::UNIT_KHZ;
      end
    end else if (rb[2:0] == mfd_pkg::MODE_DUTY) begin
      places = 2;
      r.unit = mfd_pkg::UNIT_PCT;
    end else begin
      case (fn)
        mfd_pkg::FN_VOLT: begin
          places = (rng == 0) ? 1 : 4 - rng;
          r.unit = (rng == 0) ? mfd_pkg::UNIT_MV : mfd_pkg::UNIT_V;
        end
        mfd_pkg::FN_VOLT_AC: begin
          places = 3 - rng;
          r.unit = mfd_pkg::UNIT_V;
        end
        mfd_pkg::FN_MVOLT: begin
          places = 2 - rng;
          r.unit = mfd_pkg::UNIT_MV;
        end
        mfd_pkg::FN_AMP, mfd_pkg::FN_AMP_ALT: begin
          places = 3 - rng;
          r.unit = mfd_pkg::UNIT_A;
        end
        mfd_pkg::FN_MAMP, mfd_pkg::FN_MAMP_ALT: begin
          places = 2 - rng;
          r.unit = mfd_pkg::UNIT_MA;
        end
        mfd_pkg::FN_OHM: begin
          if (rng == 0) begin
            places = 3;
            r.unit = mfd_pkg::UNIT_OHM;
          end else if (rng <= 3) begin
            places = 4 - rng;
            r.unit = mfd_pkg::UNIT_KOHM;
          end else if (rng <= 5) begin
            places = 7 - rng;
            r.unit = mfd_pkg::UNIT_MOHM;
          end else begin
            places = 2;
            r.unit = (rng == 6) ? mfd_pkg::UNIT_NS : mfd_pkg::UNIT_NONE;
          end
        end
        mfd_pkg::FN_CAP: begin
          places = 3 - (rng % 3);
          r.unit = (rng <= 2) ? mfd_pkg::UNIT_NF : mfd_pkg::UNIT_UF;
        end
        default: begin
          places = 0;
          r.unit = mfd_pkg::UNIT_NONE;
        end
      endcase
    end
    if (places < 0) places = 0;
    if (places > int'(mfd_pkg::PLACES_MAX)) places = int'(mfd_pkg::PLACES_MAX);
    r.decimal_places = 3'(places);
    r.negative = fb[4];
    r.overload = fb[3];
    r.auto_range = ~rb[6];
    r.hold = fb[0];
    r.five_digit = five;
    return r;
  endfunction

  // Advances the predictor by one accepted byte. Only a terminator that follows exactly a
  // full frame yields a reading; every terminator restarts the count, and bytes past a
  // full frame are dropped while the count parks one above the frame length.
  function automatic void take_byte(input logic [7:0] b, output bit produced,
                                    output mfd_pkg::result_t reading);
    produced = 1'b0;
    reading = '0;
    if (b == terminator) begin
      if (fill_count == mfd_pkg::FRAME_BYTES) begin
        reading = decode_reading();
        produced = 1'b1;
      end
      fill_count = 0;
    end else if (fill_count < mfd_pkg::FRAME_BYTES) begin
      frame_bytes[fill_count] = b;
      fill_count++;
    end else begin
      fill_count = mfd_pkg::FRAME_BYTES + 1;
    end
  endfunction

  // Data bytes of a well-formed frame must not look like the terminator.
  function automatic logic [7:0] clear_of_term(input logic [7:0] b);
    return (b == terminator) ? (b ^ 8'h80) : b;
  endfunction

  // Presents one byte after a random gap and holds it until the transfer. In_valid stays
  // high across back-to-back bytes; the caller that stops sending lowers it.
  task automatic send_byte(input logic [7:0] b, input exp_kind_t kind,
                           input mfd_pkg::result_t listed);
    int               gap;
    bit               produced;
    mfd_pkg::result_t reading;
    gap = calm ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    take_byte(b, produced, reading);
    case (kind)
      EXP_PREDICTED: if (produced) readings_due.push_back(reading);
      EXP_LISTED:    readings_due.push_back(listed);
      default:       ;
    endcase
    bytes_sent++;
  endtask

  // Sends the first length bytes of frame_buf and then the terminator.
  task automatic send_frame(input int length, input exp_kind_t kind,
                            input mfd_pkg::result_t listed);
    for (int k = 0; k < length; k++) send_byte(frame_buf[k], EXP_PREDICTED, NO_READING);
    send_byte(terminator, kind, listed);
  endtask

  // Stops the input side and waits until every reading has arrived and nothing that
  // could still be in the pipeline remains.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_terminator(input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_terminator_byte <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    terminator = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [16:0] want,
                             input logic [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  // Reading side: each transfer is compared with the oldest pending reading.
  always @(posedge clk) begin : reading_check
    mfd_pkg::result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (readings_due.size() == 0) begin
        $error("reading transfer with no frame pending (magnitude %0d)", out_magnitude);
        failed = 1'b1;
      end else begin
        want = readings_due.pop_front();
        check_field("magnitude", want.magnitude, out_magnitude);
        check_field("decimal_places", 17'(want.decimal_places), 17'(out_decimal_places));
        check_field("unit", 17'(want.unit), 17'(out_unit));
        check_field("negative", 17'(want.negative), 17'(out_negative));
        check_field("overload", 17'(want.overload), 17'(out_overload));
        check_field("auto_range", 17'(want.auto_range), 17'(out_auto_range));
        check_field("hold", 17'(want.hold), 17'(out_hold));
        check_field("five_digit", 17'(want.five_digit), 17'(out_five_digit));
        check_field("digit_error", 17'(want.digit_error), 17'(out_digit_error));
      end
    end
  end

  // Output back-pressure: before each reading transfer the receiver stalls for a drawn
  // number of cycles, then takes the reading as soon as it is offered. Stalls run whether
  // or not a reading is waiting, so they land on every phase of the decode.
  initial begin : reading_pacing
    int stall_cycles;
    out_stall = 1'b0;
    forever begin
      stall_cycles = calm ? 0 : $urandom_range(0, 3);
      @(negedge clk);
      out_stall <= (stall_cycles != 0);
      if (stall_cycles != 0) begin
        repeat (stall_cycles) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(out_valid === 1'b1 && out_stall === 1'b0)) @(posedge clk);
    end
  end

  // Ends the run when no channel has made a transfer for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0) ||
          (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("multimeter_frame_decoder_tb failed");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] new_term;
    int         phase_start;
    int         shape;
    int         pick;
    int         length;
    int         noise_len;
    foreach (frame_bytes[k]) frame_bytes[k] = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    cfg_valid = 1'b0;
    cfg_terminator_byte = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames under the reset terminator. Unused frame positions hold spaces.
    foreach (PLAN[r]) begin
      foreach (frame_buf[k]) frame_buf[k] = 8'h20;
      frame_buf[mfd_pkg::IDX_FN] = PLAN[r].fn;
      frame_buf[mfd_pkg::IDX_RANGE] = PLAN[r].rng_byte;
      frame_buf[mfd_pkg::IDX_FLAGS] = PLAN[r].flags;
      for (int k = 0; k < mfd_pkg::NUM_DIGITS; k++) begin
        frame_buf[mfd_pkg::IDX_DIG0 + k] =
          PLAN[r].digits[8 * (mfd_pkg::NUM_DIGITS - 1 - k) +: 8];
      end
      send_frame(int'(PLAN[r].length), PLAN[r].kind, PLAN[r].reading);
    end

    // Random phases, each under its own terminator. Most traffic is well-formed frames
    // with random content; the rest is frames of the wrong length and raw noise, which
    // may contain the terminator anywhere.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      new_term = TERM_PLAN[p];
      if (p == RANDOM_PHASE) new_term = 8'($urandom_range(0, 255));
      write_terminator(new_term);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
        calm = ($urandom_range(0, 5) == 0);
        shape = $urandom_range(0, 9);
        if (shape < 8) begin
          foreach (frame_buf[k]) frame_buf[k] = 8'($urandom_range(0, 255));
          pick = $urandom_range(0, 10);
          if (pick < 9) frame_buf[mfd_pkg::IDX_FN] = FN_LIST[pick];
          // Mostly proper ASCII digits, now and then any byte at all.
          for (int k = 0; k < mfd_pkg::NUM_DIGITS; k++) begin
            if ($urandom_range(0, 7) != 0) begin
              frame_buf[mfd_pkg::IDX_DIG0 + k] =
                mfd_pkg::ASCII_ZERO + 8'($urandom_range(0, 9));
            end
          end
          foreach (frame_buf[k]) frame_buf[k] = clear_of_term(frame_buf[k]);
          if (shape < 7) begin
            length = mfd_pkg::FRAME_BYTES;
          end else begin
            length = $urandom_range(0, mfd_pkg::FRAME_BYTES + 1);
            if (length >= mfd_pkg::FRAME_BYTES) length++;
          end
          send_frame(length, EXP_PREDICTED, NO_READING);
        end else begin
          noise_len = $urandom_range(1, 8);
          for (int k = 0; k < noise_len; k++) begin
            if ($urandom_range(0, 7) == 0) begin
              send_byte(terminator, EXP_PREDICTED, NO_READING);
            end else begin
              send_byte(8'($urandom_range(0, 255)), EXP_PREDICTED, NO_READING);
            end
          end
        end
      end
    end

    settle();
    if (!failed) begin
      $display("multimeter_frame_decoder_tb passed");
    end else begin
      $display("multimeter_frame_decoder_tb failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mfd_pkg.sv
rtl/mfd_collect.sv
rtl/mfd_decode.sv
rtl/multimeter_frame_decoder.sv
dv/multimeter_frame_decoder_tb.sv
